/* hdl/pbsp_pkg.sv */
// types, constants and state codes for the plane and box section block
// no dependencies
`timescale 1ns / 1ps

package pbsp_pkg;

  localparam int COORD_W    = 32;
  localparam int NORM_W     = 16;
  localparam int MAX_POINTS = 12;
  localparam int IDX_W      = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int NUM_W      = 50;
  localparam int MAG_W      = NUM_W - 1;
  localparam int DIVR_W     = NORM_W + 1;
  localparam int MUL_W      = COORD_W + 1;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int DIST_W     = 2 * COORD_W + 2;
  localparam int FRAC_SHIFT = 14;
  localparam int CNT_W      = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_X_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_X_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_LOW  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_HIGH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_Z_LOW  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_Z_HIGH = 3'd5;

  localparam logic [1:0] GRP_Z = 2'd0;
  localparam logic [1:0] GRP_X = 2'd1;
  localparam logic [1:0] GRP_Y = 2'd2;

  typedef struct packed {
    logic signed [NORM_W-1:0]  normal_x;
    logic signed [NORM_W-1:0]  normal_y;
    logic signed [NORM_W-1:0]  normal_z;
    logic signed [COORD_W-1:0] plane_offset;
  } in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
    logic [IDX_W-1:0]          point_index;
    logic [IDX_W-1:0]          point_count;
    logic                      empty_res;
    logic                      last;
  } out_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } point_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_EDGE,
    ST_MUL_A,
    ST_MUL_B,
    ST_NUM,
    ST_DIV_INIT,
    ST_DIV,
    ST_KEEP,
    ST_SORT_INIT,
    ST_LOAD_CUR,
    ST_CUR_WAIT,
    ST_SCAN,
    ST_DIST_X,
    ST_DIST_Y,
    ST_DIST_Z,
    ST_CMP,
    ST_EMPTY,
    ST_EMIT_RD,
    ST_EMIT_LOAD,
    ST_EMIT_WAIT
  } state_t;

endpackage

/* hdl/plane_box_section_polygon.sv */
// top level: cross-section polygon of a plane with the configured box
// depends on pbsp_pkg
//
//  port group  dir  transfer when            payload
//  in          in   in_valid & !in_stall     in_data (in_t)
//  out         out  out_valid & !out_stall   out_data (out_t)
//  cfg         in   cfg_we                   cfg_index, cfg_data
//
// one plane at a time on one shared 33x33 multiplier and a one-bit-a-cycle divider
// per edge solved: MUL_A, MUL_B, NUM, DIV_INIT, DIV, KEEP; zero-normal axes skip
// ordering: per step each unplaced point takes DIST_X, DIST_Y, DIST_Z and CMP
// each vertex sent passes EMIT_RD, EMIT_LOAD and EMIT_WAIT
// rst is synchronous; out stall holds the current vertex and the sequencer
`timescale 1ns / 1ps

module plane_box_section_polygon
  import pbsp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_t                  out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [COORD_W-1:0]    cfg_data
);

  localparam logic [MAG_W-1:0] POS_LIM = MAG_W'((64'd1 << (COORD_W - 1)) - 64'd1);
  localparam logic [MAG_W-1:0] NEG_LIM = MAG_W'(64'd1 << (COORD_W - 1));
  localparam logic [IDX_W-1:0] N_EDGES = IDX_W'(MAX_POINTS);

  state_t state, state_next;

  logic signed [COORD_W-1:0] xl, xh, yl, yh, zl, zh;
  in_t                       pl;
  logic [IDX_W-1:0]          edge_i;
  logic [IDX_W-1:0]          count;
  logic [MAX_POINTS-1:0]     taken_mask;

  logic signed [PROD_W-1:0]  prod_r, p1;
  logic signed [NUM_W-1:0]   num;
  logic [MAG_W-1:0]          dq;
  logic [DIVR_W-1:0]         rem;
  logic [DIVR_W-1:0]         dv;
  logic                      q_neg;
  logic [CNT_W-1:0]          div_cnt;

  point_t                    mem [MAX_POINTS];
  point_t                    rd_pt;
  point_t                    cur_pt;
  logic                      rd_en;
  logic [IDX_W-1:0]          rd_addr;

  logic [IDX_W-1:0]          order [MAX_POINTS];
  logic [IDX_W-1:0]          j_i, i_i, cur, best, oj;
  logic                      found;
  logic [DIST_W-1:0]         acc, bd, dist_sum;

  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [PROD_W-1:0]  prod;

  // edge table
  logic [1:0]                grp;
  logic signed [NORM_W-1:0]  na, nb, nc;
  logic signed [COORD_W-1:0] ea, eb, rlo, rhi;
  logic signed [COORD_W-1:0] v_sat;
  logic                      v_in;
  point_t                    new_pt;
  logic [DIVR_W:0]           rem_sh;
  logic                      q_bit;

  function automatic logic [COORD_W-1:0] absdiff(logic signed [COORD_W-1:0] a,
                                                 logic signed [COORD_W-1:0] b);
    logic signed [COORD_W:0] d;
    d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    return d[COORD_W] ? COORD_W'(-d) : d[COORD_W-1:0];
  endfunction

  assign grp = edge_i[3:2];

  always_comb begin
    na = pl.normal_x; nb = pl.normal_y; nc = pl.normal_z;
    ea = edge_i[1] ? xh : xl; eb = edge_i[0] ? yh : yl;
    rlo = zl; rhi = zh;
    new_pt = '{x: ea, y: eb, z: v_sat};
    case (grp)
      GRP_Z: begin
        new_pt = '{x: ea, y: eb, z: v_sat};
      end
      GRP_X: begin
        na = pl.normal_y; nb = pl.normal_z; nc = pl.normal_x;
        ea = edge_i[1] ? yh : yl; eb = edge_i[0] ? zh : zl;
        rlo = xl; rhi = xh;
        new_pt = '{x: v_sat, y: ea, z: eb};
      end
      GRP_Y: begin
        na = pl.normal_z; nb = pl.normal_x; nc = pl.normal_y;
        ea = edge_i[1] ? zh : zl; eb = edge_i[0] ? xh : xl;
        rlo = yl; rhi = yh;
        new_pt = '{x: eb, y: v_sat, z: ea};
      end
      default: begin
      end
    endcase
  end

  // saturated signed quotient and range test
  always_comb begin
    if (q_neg) begin
      v_sat = (dq > NEG_LIM) ? $signed(NEG_LIM[COORD_W-1:0]) : $signed(COORD_W'(-dq));
    end else begin
      v_sat = (dq > POS_LIM) ? $signed(POS_LIM[COORD_W-1:0]) : $signed(dq[COORD_W-1:0]);
    end
    v_in = (v_sat >= rlo) && (v_sat <= rhi);
  end

  assign rem_sh   = {rem, dq[MAG_W-1]};
  assign q_bit    = rem_sh >= {1'b0, dv};
  assign prod     = mul_a * mul_b;
  assign dist_sum = acc + DIST_W'(unsigned'(prod_r));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:      if (in_valid) state_next = ST_EDGE;
      ST_EDGE: begin
        if (edge_i >= N_EDGES) state_next = ST_SORT_INIT;
        else if (nc != '0)     state_next = ST_MUL_A;
      end
      ST_MUL_A:     state_next = ST_MUL_B;
      ST_MUL_B:     state_next = ST_NUM;
      ST_NUM:       state_next = ST_DIV_INIT;
      ST_DIV_INIT:  state_next = ST_DIV;
      ST_DIV:       if (div_cnt == CNT_W'(1)) state_next = ST_KEEP;
      ST_KEEP:      state_next = ST_EDGE;
      ST_SORT_INIT: begin
        if (count == '0)               state_next = ST_EMPTY;
        else if (count == IDX_W'(1))   state_next = ST_EMIT_RD;
        else                           state_next = ST_LOAD_CUR;
      end
      ST_LOAD_CUR:  state_next = ST_CUR_WAIT;
      ST_CUR_WAIT:  state_next = ST_SCAN;
      ST_SCAN: begin
        if (i_i == count) begin
          state_next = (j_i + IDX_W'(1) == count) ? ST_EMIT_RD : ST_LOAD_CUR;
        end else if (!taken_mask[i_i]) begin
          state_next = ST_DIST_X;
        end
      end
      ST_DIST_X:    state_next = ST_DIST_Y;
      ST_DIST_Y:    state_next = ST_DIST_Z;
      ST_DIST_Z:    state_next = ST_CMP;
      ST_CMP:       state_next = ST_SCAN;
      ST_EMPTY:     state_next = ST_EMIT_WAIT;
      ST_EMIT_RD:   state_next = ST_EMIT_LOAD;
      ST_EMIT_LOAD: state_next = ST_EMIT_WAIT;
      ST_EMIT_WAIT: begin
        if (!out_stall) state_next = out_data.last ? ST_IDLE : ST_EMIT_RD;
      end
      default:      state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall = (state != ST_IDLE);
    rd_en    = 1'b0;
    rd_addr  = i_i;
    mul_a    = MUL_W'(na);
    mul_b    = MUL_W'(ea);
    unique case (state)
      ST_MUL_A: begin
        mul_a = MUL_W'(na); mul_b = MUL_W'(ea);
      end
      ST_MUL_B: begin
        mul_a = MUL_W'(nb); mul_b = MUL_W'(eb);
      end
      ST_LOAD_CUR: begin
        rd_en = 1'b1; rd_addr = cur;
      end
      ST_SCAN: begin
        rd_en = (i_i != count) && !taken_mask[i_i]; rd_addr = i_i;
      end
      ST_DIST_X: begin
        mul_a = $signed({1'b0, absdiff(rd_pt.x, cur_pt.x)});
        mul_b = $signed({1'b0, absdiff(rd_pt.x, cur_pt.x)});
      end
      ST_DIST_Y: begin
        mul_a = $signed({1'b0, absdiff(rd_pt.y, cur_pt.y)});
        mul_b = $signed({1'b0, absdiff(rd_pt.y, cur_pt.y)});
      end
      ST_DIST_Z: begin
        mul_a = $signed({1'b0, absdiff(rd_pt.z, cur_pt.z)});
        mul_b = $signed({1'b0, absdiff(rd_pt.z, cur_pt.z)});
      end
      ST_EMIT_RD: begin
        rd_en = 1'b1; rd_addr = order[oj];
      end
      default: begin
      end
    endcase
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      xl <= '0; xh <= '0; yl <= '0; yh <= '0; zl <= '0; zh <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_X_LOW:  xl <= $signed(cfg_data);
        CFG_X_HIGH: xh <= $signed(cfg_data);
        CFG_Y_LOW:  yl <= $signed(cfg_data);
        CFG_Y_HIGH: yh <= $signed(cfg_data);
        CFG_Z_LOW:  zl <= $signed(cfg_data);
        CFG_Z_HIGH: zh <= $signed(cfg_data);
        default: begin
        end
      endcase
    end
  end

  // crossing store
  always_ff @(posedge clk) begin
    if (state == ST_KEEP && v_in && count < N_EDGES) begin
      mem[count] <= new_pt;
    end
    if (rd_en) begin
      rd_pt <= mem[rd_addr];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      out_valid  <= 1'b0;
      count      <= '0;
      taken_mask <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            count      <= '0;
            taken_mask <= '0;
          end
        end
        ST_KEEP: begin
          if (v_in && count < N_EDGES) count <= count + IDX_W'(1);
        end
        ST_SORT_INIT: begin
          taken_mask <= MAX_POINTS'(1);
        end
        ST_SCAN: begin
          if (i_i == count) taken_mask[best] <= 1'b1;
        end
        ST_EMPTY, ST_EMIT_LOAD: begin
          out_valid <= 1'b1;
        end
        ST_EMIT_WAIT: begin
          if (!out_stall) out_valid <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        pl     <= in_data;
        edge_i <= '0;
      end
      ST_EDGE: begin
        if (edge_i < N_EDGES && nc == '0) edge_i <= edge_i + IDX_W'(4);
      end
      ST_MUL_A: begin
        prod_r <= prod;
      end
      ST_MUL_B: begin
        p1     <= prod_r;
        prod_r <= prod;
      end
      ST_NUM: begin
        num <= (NUM_W'(pl.plane_offset) <<< FRAC_SHIFT) - p1[NUM_W-1:0]
               - prod_r[NUM_W-1:0];
      end
      ST_DIV_INIT: begin
        dq      <= num[NUM_W-1] ? MAG_W'(-num) : num[MAG_W-1:0];
        q_neg   <= num[NUM_W-1] ^ nc[NORM_W-1];
        dv      <= nc[NORM_W-1] ? DIVR_W'(-{nc[NORM_W-1], nc}) : DIVR_W'(nc);
        rem     <= '0;
        div_cnt <= CNT_W'(MAG_W);
      end
      ST_DIV: begin
        rem     <= q_bit ? DIVR_W'(rem_sh - {1'b0, dv}) : rem_sh[DIVR_W-1:0];
        dq      <= {dq[MAG_W-2:0], q_bit};
        div_cnt <= div_cnt - CNT_W'(1);
      end
      ST_KEEP: begin
        edge_i <= edge_i + IDX_W'(1);
      end
      ST_SORT_INIT: begin
        order[0] <= '0;
        cur      <= '0;
        j_i      <= IDX_W'(1);
        oj       <= '0;
      end
      ST_CUR_WAIT: begin
        cur_pt <= rd_pt;
        i_i    <= '0;
        found  <= 1'b0;
      end
      ST_SCAN: begin
        if (i_i == count) begin
          order[j_i] <= best;
          cur        <= best;
          j_i        <= j_i + IDX_W'(1);
        end else if (taken_mask[i_i]) begin
          i_i <= i_i + IDX_W'(1);
        end
      end
      ST_DIST_X: begin
        prod_r <= prod;
      end
      ST_DIST_Y: begin
        acc    <= DIST_W'(unsigned'(prod_r));
        prod_r <= prod;
      end
      ST_DIST_Z: begin
        acc    <= dist_sum;
        prod_r <= prod;
      end
      ST_CMP: begin
        if (!found || dist_sum < bd) begin
          found <= 1'b1;
          best  <= i_i;
          bd    <= dist_sum;
        end
        i_i <= i_i + IDX_W'(1);
      end
      ST_EMPTY: begin
        out_data <= {{(3 * COORD_W + 2 * IDX_W){1'b0}}, 2'b11};
      end
      ST_EMIT_LOAD: begin
        out_data.point_x     <= rd_pt.x;
        out_data.point_y     <= rd_pt.y;
        out_data.point_z     <= rd_pt.z;
        out_data.point_index <= oj;
        out_data.point_count <= count;
        out_data.empty_res   <= 1'b0;
        out_data.last        <= (oj + IDX_W'(1) == count);
      end
      ST_EMIT_WAIT: begin
        if (!out_stall) oj <= oj + IDX_W'(1);
      end
      default: begin
      end
    endcase
  end

endmodule

/* hdl/pbsp_checker.sv */
// port-level checks for the plane and box section block, bound to the top level
// depends on pbsp_pkg and plane_box_section_polygon
`timescale 1ns / 1ps

module pbsp_checker
  import pbsp_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // no result right after an input transfer
  a_in_then_quiet: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> !out_valid)
    else $error("result shown right after input transfer");

  // no new plane while a result is pending
  a_busy_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input open while result pending");

  // a miss is a single closing transfer with zero count
  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.empty_res |->
      out_data.last && out_data.point_count == '0 && out_data.point_index == '0)
    else $error("bad empty result");

  // vertex index within the run
  a_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.empty_res |->
      out_data.point_index < out_data.point_count &&
      out_data.last == (out_data.point_index + 4'd1 == out_data.point_count))
    else $error("vertex index out of run");

endmodule

bind plane_box_section_polygon pbsp_checker u_pbsp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

/* bench/plane_box_section_polygon_tb.sv */
// self-checking bench for plane_box_section_polygon: planes go in, ordered
// section vertices are predicted in the bench and checked as they come out
// depends on pbsp_pkg and plane_box_section_polygon
`timescale 1ns / 1ps

module plane_box_section_polygon_tb;
  import pbsp_pkg::*;

  localparam longint CYCLE_LIMIT = 3000000;
  localparam longint COORD_MAX = 64'sd2147483647;
  localparam longint COORD_MIN = -64'sd2147483648;
  localparam longint ONE = 64'sd65536;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_X_LOW;
  logic [COORD_W-1:0] cfg_data = '0;

  plane_box_section_polygon dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  in_t pending_planes[$];
  out_t expected_vertices[$];
  longint box_lo[3];
  longint box_hi[3];
  bit calm = 0;
  int send_gap = 0;
  int stall_gap = 0;
  int errors = 0;
  int planes_sent = 0;
  int vertices_seen = 0;
  int empty_seen = 0;
  longint cycles = 0;

  longint sec_x[MAX_POINTS];
  longint sec_y[MAX_POINTS];
  longint sec_z[MAX_POINTS];
  int sec_n;

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  function automatic longint solve_edge(longint off, longint na, longint a, longint nb,
                                        longint b, longint nc);
    longint q;
    q = (off * 16384 - na * a - nb * b) / nc;
    if (q > COORD_MAX) q = COORD_MAX;
    if (q < COORD_MIN) q = COORD_MIN;
    return q;
  endfunction

  function automatic void keep_crossing(longint x, longint y, longint z);
    if (sec_n < MAX_POINTS) begin
      sec_x[sec_n] = x;
      sec_y[sec_n] = y;
      sec_z[sec_n] = z;
      sec_n++;
    end
  endfunction

  function automatic logic [65:0] gap_sq(int i, int j);
    logic [65:0] s;
    logic [65:0] d;
    longint dx, dy, dz;
    dx = sec_x[i] - sec_x[j];
    dy = sec_y[i] - sec_y[j];
    dz = sec_z[i] - sec_z[j];
    d = (dx < 0) ? -dx : dx;
    s = d * d;
    d = (dy < 0) ? -dy : dy;
    s = s + d * d;
    d = (dz < 0) ? -dz : dz;
    s = s + d * d;
    return s;
  endfunction

  task automatic predict_section(in_t p);
    longint nx, ny, nz, off, v;
    longint xl, xh, yl, yh, zl, zh;
    int order[MAX_POINTS];
    bit taken[MAX_POINTS];
    int cur, best;
    bit found;
    logic [65:0] bd, d;
    out_t o;
    nx = p.normal_x; ny = p.normal_y; nz = p.normal_z; off = p.plane_offset;
    xl = box_lo[0]; xh = box_hi[0]; yl = box_lo[1];
    yh = box_hi[1]; zl = box_lo[2]; zh = box_hi[2];
    sec_n = 0;
    if (nz != 0) begin
      v = solve_edge(off, nx, xl, ny, yl, nz); if (v >= zl && v <= zh) keep_crossing(xl, yl, v);
      v = solve_edge(off, nx, xl, ny, yh, nz); if (v >= zl && v <= zh) keep_crossing(xl, yh, v);
      v = solve_edge(off, nx, xh, ny, yl, nz); if (v >= zl && v <= zh) keep_crossing(xh, yl, v);
      v = solve_edge(off, nx, xh, ny, yh, nz); if (v >= zl && v <= zh) keep_crossing(xh, yh, v);
    end
    if (nx != 0) begin
      v = solve_edge(off, ny, yl, nz, zl, nx); if (v >= xl && v <= xh) keep_crossing(v, yl, zl);
      v = solve_edge(off, ny, yl, nz, zh, nx); if (v >= xl && v <= xh) keep_crossing(v, yl, zh);
      v = solve_edge(off, ny, yh, nz, zl, nx); if (v >= xl && v <= xh) keep_crossing(v, yh, zl);
      v = solve_edge(off, ny, yh, nz, zh, nx); if (v >= xl && v <= xh) keep_crossing(v, yh, zh);
    end
    if (ny != 0) begin
      v = solve_edge(off, nz, zl, nx, xl, ny); if (v >= yl && v <= yh) keep_crossing(xl, v, zl);
      v = solve_edge(off, nz, zl, nx, xh, ny); if (v >= yl && v <= yh) keep_crossing(xh, v, zl);
      v = solve_edge(off, nz, zh, nx, xl, ny); if (v >= yl && v <= yh) keep_crossing(xl, v, zh);
      v = solve_edge(off, nz, zh, nx, xh, ny); if (v >= yl && v <= yh) keep_crossing(xh, v, zh);
    end
    if (sec_n == 0) begin
      o = '0;
      o.empty_res = 1'b1;
      o.last = 1'b1;
      expected_vertices.push_back(o);
      return;
    end
    foreach (taken[i]) taken[i] = 0;
    order[0] = 0;
    taken[0] = 1;
    cur = 0;
    for (int j = 1; j < sec_n; j++) begin
      found = 0;
      best = 0;
      bd = '0;
      for (int i = 0; i < sec_n; i++) begin
        if (!taken[i]) begin
          d = gap_sq(i, cur);
          if (!found || d < bd) begin
            found = 1;
            best = i;
            bd = d;
          end
        end
      end
      order[j] = best;
      taken[best] = 1;
      cur = best;
    end
    for (int j = 0; j < sec_n; j++) begin
      o.point_x = sec_x[order[j]][31:0];
      o.point_y = sec_y[order[j]][31:0];
      o.point_z = sec_z[order[j]][31:0];
      o.point_index = j[3:0];
      o.point_count = sec_n[3:0];
      o.empty_res = 1'b0;
      o.last = (j == sec_n - 1);
      expected_vertices.push_back(o);
    end
  endtask

  // plane driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_section(in_data);
        planes_sent++;
      end
      if (in_valid && in_stall) begin
      end else if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_planes.size() > 0) begin
        in_valid <= 1'b1;
        in_data <= pending_planes.pop_front();
        send_gap = pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // vertex monitor
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_gap = 0;
    end else begin
      if (out_valid && !out_stall) begin
        vertices_seen++;
        if (out_data.empty_res) empty_seen++;
        if (expected_vertices.size() == 0) begin
          $display("%0t: unexpected vertex %h", $time, out_data);
          errors++;
        end else begin
          out_t e;
          e = expected_vertices.pop_front();
          if (e !== out_data) begin
            $display("%0t: mismatch expected x=%h y=%h z=%h idx=%0d cnt=%0d empty=%0b last=%0b",
                     $time, e.point_x, e.point_y, e.point_z, e.point_index, e.point_count,
                     e.empty_res, e.last);
            $display("%0t:          actual x=%h y=%h z=%h idx=%0d cnt=%0d empty=%0b last=%0b",
                     $time, out_data.point_x, out_data.point_y, out_data.point_z,
                     out_data.point_index, out_data.point_count, out_data.empty_res,
                     out_data.last);
            errors++;
          end
        end
      end
      if (stall_gap > 0) begin
        stall_gap--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        stall_gap = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout", $time);
      $display("plane_box_section_polygon_tb NOT OK");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx <= CFG_Z_HIGH) begin
      if (idx[0]) box_hi[idx / 2] = longint'(signed'(val));
      else box_lo[idx / 2] = longint'(signed'(val));
    end
  endtask

  task automatic set_box(longint xl, longint xh, longint yl, longint yh,
                         longint zl, longint zh);
    write_reg(CFG_X_LOW, xl[31:0]);
    write_reg(CFG_X_HIGH, xh[31:0]);
    write_reg(CFG_Y_LOW, yl[31:0]);
    write_reg(CFG_Y_HIGH, yh[31:0]);
    write_reg(CFG_Z_LOW, zl[31:0]);
    write_reg(CFG_Z_HIGH, zh[31:0]);
    // out-of-range indexes must be ignored
    write_reg(3'd6, $urandom);
    write_reg(3'd7, $urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_planes.size() != 0 || expected_vertices.size() != 0 || in_valid);
  endtask

  function automatic longint pick_between(longint lo, longint hi);
    longint unsigned r;
    if (hi <= lo) return lo;
    r = {$urandom, $urandom};
    return lo + longint'(r % longint'(hi - lo + 1));
  endfunction

  function automatic logic [15:0] pick_normal();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return 16'sd0;
      1: begin
        case ($urandom_range(0, 3))
          0: return 16'sd16384;
          1: return -16'sd16384;
          2: return 16'h8000;
          default: return 16'h7fff;
        endcase
      end
      default: return 16'($urandom_range(0, 32768) - 16384);
    endcase
  endfunction

  function automatic in_t make_plane();
    in_t p;
    longint px, py, pz, s;
    p.normal_x = pick_normal();
    p.normal_y = pick_normal();
    p.normal_z = pick_normal();
    if ($urandom_range(0, 9) < 8) begin
      // plane through a point of the box, so it usually cuts it
      px = pick_between(box_lo[0], box_hi[0]);
      py = pick_between(box_lo[1], box_hi[1]);
      pz = pick_between(box_lo[2], box_hi[2]);
      s = (longint'(p.normal_x) * px + longint'(p.normal_y) * py
           + longint'(p.normal_z) * pz) / 16384;
      if (s > COORD_MAX) s = COORD_MAX;
      if (s < COORD_MIN) s = COORD_MIN;
      p.plane_offset = s[31:0];
    end else begin
      p.plane_offset = $urandom;
    end
    return p;
  endfunction

  function automatic in_t plane_of(int nx, int ny, int nz, longint off);
    in_t p;
    p.normal_x = 16'(nx);
    p.normal_y = 16'(ny);
    p.normal_z = 16'(nz);
    p.plane_offset = off[31:0];
    return p;
  endfunction

  initial begin
    longint lo, sz;
    foreach (box_lo[i]) begin
      box_lo[i] = 0;
      box_hi[i] = 0;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // zero box from reset: every crossing coincides
    pending_planes.push_back(plane_of(9459, 9459, 9459, 0));
    pending_planes.push_back(plane_of(0, 0, 16384, 0));
    wait_idle();

    // unit cube, directed planes
    set_box(-ONE, ONE, -ONE, ONE, -ONE, ONE);
    pending_planes.push_back(plane_of(0, 0, 0, 0));
    pending_planes.push_back(plane_of(16384, 0, 0, 0));
    pending_planes.push_back(plane_of(0, 16384, 0, ONE / 2));
    pending_planes.push_back(plane_of(0, 0, -16384, ONE));
    pending_planes.push_back(plane_of(0, 0, 16384, 2 * ONE));
    pending_planes.push_back(plane_of(9459, 9459, 9459, 0));
    pending_planes.push_back(plane_of(9459, 9459, 9459, 113512));
    pending_planes.push_back(plane_of(11585, 11585, 0, 0));
    pending_planes.push_back(plane_of(-32768, 0, 0, ONE));
    pending_planes.push_back(plane_of(32767, -32768, 16384, 0));
    pending_planes.push_back(plane_of(1, 1, 1, 0));
    pending_planes.push_back(plane_of(1, 0, 0, COORD_MAX));
    pending_planes.push_back(plane_of(-1, 0, 0, COORD_MIN));
    pending_planes.push_back(plane_of(16384, 16384, 16384, COORD_MAX));
    pending_planes.push_back(plane_of(-16384, 16384, -16384, COORD_MIN));
    pending_planes.push_back(plane_of(8192, -8192, 14189, -1));
    wait_idle();

    // full range box and an inverted box
    set_box(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX);
    pending_planes.push_back(plane_of(16384, 0, 0, COORD_MAX));
    pending_planes.push_back(plane_of(1, 1, 1, COORD_MIN));
    pending_planes.push_back(plane_of(9459, -9459, 9459, 0));
    for (int k = 0; k < 30; k++) pending_planes.push_back(make_plane());
    wait_idle();
    set_box(ONE, -ONE, -ONE, ONE, ONE, -ONE);
    for (int k = 0; k < 20; k++) pending_planes.push_back(make_plane());
    wait_idle();

    // random boxes, mostly small, some stretches with no idling
    for (int ph = 0; ph < 8; ph++) begin
      calm = (ph % 3 == 2);
      lo = pick_between(-ONE * 1000, ONE * 1000);
      sz = (ph == 7) ? 64'sd0 : pick_between(0, ONE * 64);
      set_box(lo, lo + sz, lo - pick_between(0, ONE), lo + sz,
              pick_between(COORD_MIN, COORD_MAX - 4 * ONE), 0);
      set_box(box_lo[0], box_hi[0], box_lo[1], box_hi[1],
              box_lo[2], box_lo[2] + pick_between(0, ONE * 4));
      for (int k = 0; k < 32; k++) pending_planes.push_back(make_plane());
      wait_idle();
    end
    calm = 0;

    repeat (200) @(posedge clk);
    $display("%0d planes sent through %0d box settings, %0d vertices checked (%0d empty)",
             planes_sent, 12, vertices_seen, empty_seen);
    if (errors == 0) begin
      $display("plane_box_section_polygon_tb OK");
    end else begin
      $display("plane_box_section_polygon_tb NOT OK");
    end
    $finish;
  end

endmodule
